// ===== hdl/bdq_pkg.sv =====
package bdq_pkg;

    // Field widths of the stream payload
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    // Most results a single list command produces
    localparam int RESULT_LIMIT = 32;

    // Operation codes on the input side
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd4;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    // Decoded command handed from the front end to the execution unit
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic                      list;
        logic                      search;
        logic                      front_end;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

// ===== hdl/bounded_deque_with_search_top.sv =====
// Bounded double-ended queue of signed 32-bit values with linear search.
// Slave channel: one transaction per operation; tuser carries the operation
// (push front, push back, pop front, pop back, list, search), tdata the value
// or search key. Codes 6 and 7 are accepted and discarded without a result.
// Master channel: tdata carries item_value and position, tuser the status,
// tlast marks the final result of an operation.
// Accepted operations enter a two-entry command queue; the execution unit
// takes one operation at a time from it.
// A push, a push when full, or a pop or list on an empty sequence has its result
// registered as the unit takes it from the queue; a pop or the first listed
// value is registered from a registered read of the element store. A search
// reads the entries in order from the front and ends at the first match or end.
// A list then streams one value per cycle while the receiver is ready, at most
// 32 values. Pushes are taken at one operation per cycle while the output is
// not stalled; a pop, list or search holds the unit until its last result.
// After reset the sequence is empty; no clearing pass is run.
// When the receiver holds tready low the result stays in the output register,
// execution pauses and the queue fills, after which the slave tready drops.
module bounded_deque_with_search_top #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] item_value, [37:32] position
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast
);

    import bdq_pkg::*;

    logic                      q_valid;
    t_cmd                      q_cmd;
    logic                      q_take;
    logic signed [VALUE_W-1:0] out_value;
    logic [POS_W-1:0]          out_pos;

    bdq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_op      (i_s_axis_tuser),
        .i_value   (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_take  (q_take)
    );

    bdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_take     (q_take),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_status (o_m_axis_tuser),
        .o_out_value  (out_value),
        .o_out_pos    (out_pos),
        .o_out_last   (o_m_axis_tlast)
    );

    // Pack the result payload, padded to whole bytes
    assign o_m_axis_tdata = {2'b00, out_pos, out_value};

endmodule

// ===== hdl/bdq_ram.sv =====
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds while idle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/bdq_front.sv =====
module bdq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_valid,
    output logic                               o_s_ready,
    input  logic [bdq_pkg::OP_W-1:0]           i_op,
    input  logic signed [bdq_pkg::VALUE_W-1:0] i_value,
    output logic                               o_q_valid,
    output bdq_pkg::t_cmd                      o_q_cmd,
    input  logic                               i_q_take
);

    import bdq_pkg::*;

    t_cmd       dec_cmd;
    logic       dec_ok;
    logic       accept;
    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic [1:0] n_fill;

    // Classify the operation; unused codes are dropped here
    always_comb begin
        dec_cmd           = '0;
        dec_cmd.value     = i_value;
        dec_cmd.front_end = (i_op == OP_PUSH_FRONT) || (i_op == OP_POP_FRONT);
        dec_ok            = 1'b1;
        unique case (i_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: dec_cmd.push   = 1'b1;
            OP_POP_FRONT, OP_POP_BACK:   dec_cmd.pop    = 1'b1;
            OP_LIST:                     dec_cmd.list   = 1'b1;
            OP_SEARCH:                   dec_cmd.search = 1'b1;
            default:                     dec_ok         = 1'b0;
        endcase
    end

    assign o_s_ready = (r_fill != 2'd2);
    assign accept    = i_s_valid && o_s_ready && dec_ok;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd   = r_slot[r_rd_ptr];

    // Two-entry command queue
    always_comb begin
        n_fill = r_fill;
        if (accept && !(o_q_valid && i_q_take)) begin
            n_fill = r_fill + 2'd1;
        end else if (!accept && o_q_valid && i_q_take) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (o_q_valid && i_q_take) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

// ===== hdl/bdq_back.sv =====
module bdq_back #(
    parameter int CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  bdq_pkg::t_cmd                       i_q_cmd,
    output logic                                o_q_take,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bdq_pkg::STATUS_W-1:0]        o_out_status,
    output logic signed [bdq_pkg::VALUE_W-1:0]  o_out_value,
    output logic [bdq_pkg::POS_W-1:0]           o_out_pos,
    output logic                                o_out_last
);

    import bdq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;
    localparam logic [1:0] S_SRCH = 2'd3;

    logic [1:0]                r_state,      n_state;
    logic [IW-1:0]             r_front,      n_front;
    logic [CW-1:0]             r_count,      n_count;
    logic [CW-1:0]             r_idx,        n_idx;
    logic                      r_pend,       n_pend;
    logic [CW-1:0]             r_pend_off,   n_pend_off;
    logic signed [VALUE_W-1:0] r_key,        n_key;
    logic                      r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0]       r_out_status, n_out_status;
    logic signed [VALUE_W-1:0] r_out_value,  n_out_value;
    logic [POS_W-1:0]          r_out_pos,    n_out_pos;
    logic                      r_out_last,   n_out_last;

    logic                      out_free;
    logic                      ram_wr_en;
    logic [IW-1:0]             ram_wr_addr;
    logic                      ram_rd_en;
    logic [IW-1:0]             ram_rd_addr;
    logic [VALUE_W-1:0]        ram_rd_data;
    logic                      hit;
    logic                      list_last;

    // Store slot of a given offset from the front, wrapped once
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] front,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(front) + (CW + 1)'(off);
        if (s >= (CW + 1)'(CAPACITY)) begin
            s = s - (CW + 1)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    // 1-based position, at the wider of the count and position widths
    function automatic logic [PW-1:0] pos_of(input logic [CW-1:0] off);
        return PW'(off) + PW'(1);
    endfunction

    bdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_q_cmd.value),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign hit       = r_pend && (ram_rd_data == r_key);
    assign list_last = (pos_of(r_idx) == PW'(r_count)) ||
                       (pos_of(r_idx) == PW'(RESULT_LIMIT));

    // Command execution
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_off   = r_pend_off;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        o_q_take     = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = slot_of(r_front, r_count);
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_take     = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_value  = '0;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    if (i_q_cmd.push) begin
                        n_out_valid = 1'b1;
                        if (r_count == CW'(CAPACITY)) begin
                            n_out_status = STAT_FULL;
                        end else begin
                            ram_wr_en = 1'b1;
                            n_count   = r_count + CW'(1);
                            if (i_q_cmd.front_end) begin
                                n_front     = (r_front == '0) ? IW'(CAPACITY - 1)
                                                              : r_front - IW'(1);
                                ram_wr_addr = n_front;
                            end
                        end
                    end else if (i_q_cmd.pop || i_q_cmd.list) begin
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STAT_EMPTY;
                        end else if (i_q_cmd.list) begin
                            ram_rd_en = 1'b1;
                            n_idx     = '0;
                            n_state   = S_LIST;
                        end else begin
                            ram_rd_en = 1'b1;
                            n_count   = r_count - CW'(1);
                            n_state   = S_POP;
                            if (i_q_cmd.front_end) begin
                                n_front = (r_front == IW'(CAPACITY - 1)) ? '0
                                                                         : r_front + IW'(1);
                            end else begin
                                ram_rd_addr = slot_of(r_front, r_count - CW'(1));
                            end
                        end
                    end else begin
                        n_key   = i_q_cmd.value;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SRCH;
                    end
                end
            end

            S_POP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_value  = ram_rd_data;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // One value per cycle while the output is free; the next read overlaps the current result
            S_LIST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_value  = ram_rd_data;
                    n_out_pos    = POS_W'(pos_of(r_idx));
                    n_out_last   = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = slot_of(r_front, r_idx + CW'(1));
                        n_idx       = r_idx + CW'(1);
                    end
                end
            end

            // Compare the entry from the previous store read while fetching the next one
            S_SRCH: begin
                if (hit || (!r_pend && (r_idx == r_count))) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = S_IDLE;
                        if (hit) begin
                            n_out_status = STAT_OK;
                            n_out_value  = r_key;
                            n_out_pos    = POS_W'(pos_of(r_pend_off));
                        end else begin
                            n_out_status = STAT_NOT_FOUND;
                            n_out_value  = '0;
                            n_out_pos    = '0;
                        end
                    end
                end else if (r_idx < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_of(r_front, r_idx);
                    n_pend      = 1'b1;
                    n_pend_off  = r_idx;
                    n_idx       = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pend_off   <= n_pend_off;
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_value  = r_out_value;
    assign o_out_pos    = r_out_pos;
    assign o_out_last   = r_out_last;

endmodule
